@@ hdl/lslrm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the lane / stop-line ridge mask.
// No dependencies.
package lslrm_pkg;

  localparam int MAX_WIDTH_DEF       = 2048;
  localparam int MAX_HEIGHT_DEF      = 2048;
  localparam int MAX_LANE_OFFSET_DEF = 32;
  localparam int MAX_STOP_OFFSET_DEF = 32;

  localparam int PIX_W      = 8;   // gray level
  localparam int POS_W      = 11;  // row/column fields on the result port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // register reset values
  localparam int RST_IMAGE_WIDTH      = 1280;
  localparam int RST_IMAGE_HEIGHT     = 720;
  localparam int RST_LANE_OFFSET      = 15;
  localparam int RST_LANE_THRESHOLD   = 25;
  localparam int RST_STOP_OFFSET      = 15;
  localparam int RST_STOP_THRESHOLD   = 40;
  localparam int RST_BRIGHT_THRESHOLD = 170;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH      = 3'd0,
    REG_IMAGE_HEIGHT     = 3'd1,
    REG_LANE_OFFSET      = 3'd2,
    REG_LANE_THRESHOLD   = 3'd3,
    REG_STOP_OFFSET      = 3'd4,
    REG_STOP_THRESHOLD   = 3'd5,
    REG_BRIGHT_THRESHOLD = 3'd6
  } cfg_reg_t;

endpackage

@@ hdl/lslrm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// Read-first on an address collision; no dependencies.
module lslrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/lane_and_stop_line_ridge_mask.sv @@
`timescale 1ns / 1ps
// Lane / stop-line ridge mask top level. Uses lslrm_pkg and lslrm_ram.
// Horizontal window and vertical line store both live in RAM.
//
// Takes one gray pixel per clock in raster order, unless the held output
// backs up the pipeline, and returns one result per pixel. The window and
// line-store RAMs are written in the cycle the pixel is taken; their
// registered read lands in stage 1 with the pixel, and the result is then
// registered in the output stage. The line store holds 2*MAX_STOP_OFFSET
// rows of MAX_WIDTH pixels and is kept twice so both vertical neighbors are
// read together; the horizontal window is likewise a pair of small circular
// RAMs. There is no clearing pass: stop decisions for rows whose neighbor
// rows were never written since reset carry undefined marks. Border pixels
// (col < 2*lane_offset, row < 2*stop_offset) come out with their valid flag
// low and mark zero. Register values out of range are clamped at write time;
// configuration is only to be written while no pixel is in flight.
module lane_and_stop_line_ridge_mask
  import lslrm_pkg::*;
#(
  parameter int MAX_WIDTH       = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT      = MAX_HEIGHT_DEF,
  parameter int MAX_LANE_OFFSET = MAX_LANE_OFFSET_DEF,
  parameter int MAX_STOP_OFFSET = MAX_STOP_OFFSET_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_gray,
  input  logic                  in_frame_start,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_lane_valid,
  output logic [POS_W-1:0]      out_lane_row,
  output logic [POS_W-1:0]      out_lane_col,
  output logic                  out_lane_mark,
  output logic                  out_stop_valid,
  output logic [POS_W-1:0]      out_stop_row,
  output logic [POS_W-1:0]      out_stop_col,
  output logic                  out_stop_mark,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);          // column
  localparam int RW   = $clog2(MAX_HEIGHT);         // row
  localparam int WW   = CW + 1;                     // width setting
  localparam int HW   = RW + 1;                     // height setting
  localparam int LOW  = $clog2(MAX_LANE_OFFSET + 1);
  localparam int SOW  = $clog2(MAX_STOP_OFFSET + 1);
  localparam int RING = 2 * MAX_STOP_OFFSET;        // line-store rows
  localparam int SW   = $clog2(RING);
  localparam int PW   = $clog2(2 * MAX_LANE_OFFSET + 1);
  localparam int WIN_DEPTH = 2 ** PW;
  localparam int LS_DEPTH  = RING * (2 ** CW);
  localparam int LS_AW     = $clog2(LS_DEPTH);
  localparam int LCMP = (CW > LOW + 1) ? CW : LOW + 1;
  localparam int SCMP = (RW > SOW + 1) ? RW : SOW + 1;

  localparam int W_RST  = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
  localparam int H_RST  = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;
  localparam int LO_RST = (RST_LANE_OFFSET > MAX_LANE_OFFSET) ? MAX_LANE_OFFSET
                                                              : RST_LANE_OFFSET;
  localparam int SO_RST = (RST_STOP_OFFSET > MAX_STOP_OFFSET) ? MAX_STOP_OFFSET
                                                              : RST_STOP_OFFSET;

  // ---------------------------------------------------------------- config
  logic [WW-1:0]    w_r, w_nxt;
  logic [HW-1:0]    h_r, h_nxt;
  logic [LOW-1:0]   lo_r, lo_nxt;
  logic [SOW-1:0]   so_r, so_nxt;
  logic [PIX_W-1:0] lane_thr_r, lane_thr_nxt;
  logic [PIX_W-1:0] stop_thr_r, stop_thr_nxt;
  logic [PIX_W-1:0] bright_thr_r, bright_thr_nxt;
  logic             cfg_we;
  logic [5:0]       cfg_off;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_off   = cfg_data[5:0];

  always_comb begin
    w_nxt          = w_r;
    h_nxt          = h_r;
    lo_nxt         = lo_r;
    so_nxt         = so_r;
    lane_thr_nxt   = lane_thr_r;
    stop_thr_nxt   = stop_thr_r;
    bright_thr_nxt = bright_thr_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_data == '0)                  w_nxt = WW'(1);
          else if (int'(cfg_data) > MAX_WIDTH) w_nxt = WW'(MAX_WIDTH);
          else                                 w_nxt = WW'(cfg_data);
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_data == '0)                   h_nxt = HW'(1);
          else if (int'(cfg_data) > MAX_HEIGHT) h_nxt = HW'(MAX_HEIGHT);
          else                                  h_nxt = HW'(cfg_data);
        end
        REG_LANE_OFFSET: begin
          if (cfg_off == '0)                        lo_nxt = LOW'(1);
          else if (int'(cfg_off) > MAX_LANE_OFFSET) lo_nxt = LOW'(MAX_LANE_OFFSET);
          else                                      lo_nxt = LOW'(cfg_off);
        end
        REG_LANE_THRESHOLD:   lane_thr_nxt = cfg_data[PIX_W-1:0];
        REG_STOP_OFFSET: begin
          if (cfg_off == '0)                        so_nxt = SOW'(1);
          else if (int'(cfg_off) > MAX_STOP_OFFSET) so_nxt = SOW'(MAX_STOP_OFFSET);
          else                                      so_nxt = SOW'(cfg_off);
        end
        REG_STOP_THRESHOLD:   stop_thr_nxt = cfg_data[PIX_W-1:0];
        REG_BRIGHT_THRESHOLD: bright_thr_nxt = cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r          <= WW'(W_RST);
      h_r          <= HW'(H_RST);
      lo_r         <= LOW'(LO_RST);
      so_r         <= SOW'(SO_RST);
      lane_thr_r   <= PIX_W'(RST_LANE_THRESHOLD);
      stop_thr_r   <= PIX_W'(RST_STOP_THRESHOLD);
      bright_thr_r <= PIX_W'(RST_BRIGHT_THRESHOLD);
    end else begin
      w_r          <= w_nxt;
      h_r          <= h_nxt;
      lo_r         <= lo_nxt;
      so_r         <= so_nxt;
      lane_thr_r   <= lane_thr_nxt;
      stop_thr_r   <= stop_thr_nxt;
      bright_thr_r <= bright_thr_nxt;
    end
  end

  // ----------------------------------------------------------- flow control
  logic s1_v_r, out_valid_r;
  logic s1_adv, s2_adv, acc;

  assign s2_adv   = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_stall = !s1_adv;
  assign acc      = in_valid && s1_adv;

  // ------------------------------------------------------- position (stage 0)
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [PW-1:0] wptr_r, wptr_nxt;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [SW-1:0] slot;
  logic [HW-1:0] row_inc;
  logic [WW-1:0] col_inc;
  logic [SW:0]   slot_mid_t, slot_far_t;
  logic [SW-1:0] slot_mid, slot_far;
  logic          lane_v, stop_v;

  function automatic logic [SW-1:0] slot_step(input logic [SW-1:0] s);
    slot_step = (int'(s) == RING - 1) ? '0 : s + SW'(1);
  endfunction

  always_comb begin
    col     = col_cnt_r;
    row     = row_cnt_r;
    slot    = slot_r;
    row_inc = HW'(row_cnt_r) + HW'(1);
    if (in_frame_start) begin
      col  = '0;
      row  = '0;
      slot = '0;
    end else begin
      if (WW'(col_cnt_r) >= w_r) begin
        col  = '0;
        slot = slot_step(slot_r);
        if (row_inc >= h_r) begin
          row  = '0;
          slot = '0;
        end else begin
          row  = row_inc[RW-1:0];
        end
      end else if (HW'(row_cnt_r) >= h_r) begin
        row  = '0;
        slot = '0;
      end
    end
  end

  // next position after this pixel
  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    slot_nxt    = slot_r;
    wptr_nxt    = wptr_r;
    col_inc     = WW'(col) + WW'(1);
    if (acc) begin
      wptr_nxt = wptr_r + PW'(1);
      if (col_inc >= w_r) begin
        col_cnt_nxt = '0;
        if (HW'(row) + HW'(1) >= h_r) begin
          row_cnt_nxt = '0;
          slot_nxt    = '0;
        end else begin
          row_cnt_nxt = row + RW'(1);
          slot_nxt    = slot_step(slot);
        end
      end else begin
        col_cnt_nxt = col_inc[CW-1:0];
        row_cnt_nxt = row;
        slot_nxt    = slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      slot_r    <= '0;
      wptr_r    <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      slot_r    <= slot_nxt;
      wptr_r    <= wptr_nxt;
    end
  end

  // ring slots of the rows stop_offset and 2*stop_offset above
  always_comb begin
    slot_mid_t = (SW+1)'(slot) + (SW+1)'(RING) - (SW+1)'(so_r);
    slot_far_t = (SW+1)'(slot) + (SW+1)'(RING) - (SW+1)'({so_r, 1'b0});
    slot_mid   = (int'(slot_mid_t) >= RING) ? SW'(slot_mid_t - (SW+1)'(RING))
                                            : slot_mid_t[SW-1:0];
    slot_far   = (int'(slot_far_t) >= RING) ? SW'(slot_far_t - (SW+1)'(RING))
                                            : slot_far_t[SW-1:0];
  end

  assign lane_v = LCMP'(col) >= LCMP'({lo_r, 1'b0});
  assign stop_v = SCMP'(row) >= SCMP'({so_r, 1'b0});

  // ------------------------------------------------------------- memories
  // Writes land in the acceptance cycle; read-first covers a neighbor slot
  // that aliases the write slot, and a later pixel sees the written value.
  logic [PIX_W-1:0] win_mid, win_far, ls_mid, ls_far;
  logic [LS_AW-1:0] ls_waddr, ls_mid_addr, ls_far_addr;

  assign ls_waddr    = LS_AW'({slot, col});
  assign ls_mid_addr = LS_AW'({slot_mid, col});
  assign ls_far_addr = LS_AW'({slot_far, col});

  lslrm_ram #(.WIDTH(PIX_W), .DEPTH(WIN_DEPTH)) u_win_mid (
    .clk   (clk),
    .we    (acc),
    .waddr (wptr_r),
    .wdata (in_gray),
    .re    (acc),
    .raddr (wptr_r - PW'(lo_r)),
    .rdata (win_mid)
  );

  lslrm_ram #(.WIDTH(PIX_W), .DEPTH(WIN_DEPTH)) u_win_far (
    .clk   (clk),
    .we    (acc),
    .waddr (wptr_r),
    .wdata (in_gray),
    .re    (acc),
    .raddr (wptr_r - PW'({lo_r, 1'b0})),
    .rdata (win_far)
  );

  lslrm_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_ls_mid (
    .clk   (clk),
    .we    (acc),
    .waddr (ls_waddr),
    .wdata (in_gray),
    .re    (acc),
    .raddr (ls_mid_addr),
    .rdata (ls_mid)
  );

  lslrm_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_ls_far (
    .clk   (clk),
    .we    (acc),
    .waddr (ls_waddr),
    .wdata (in_gray),
    .re    (acc),
    .raddr (ls_far_addr),
    .rdata (ls_far)
  );

  // ---------------------------------------------------------------- stage 1
  logic [PIX_W-1:0] s1_px_r;
  logic [POS_W-1:0] s1_row_r, s1_col_r, s1_lane_col_r, s1_stop_row_r;
  logic             s1_lane_v_r, s1_stop_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r       <= in_gray;
      s1_row_r      <= POS_W'(row);
      s1_col_r      <= POS_W'(col);
      s1_lane_v_r   <= lane_v;
      s1_stop_v_r   <= stop_v;
      s1_lane_col_r <= lane_v ? POS_W'(col - CW'(lo_r)) : '0;
      s1_stop_row_r <= stop_v ? POS_W'(row - RW'(so_r)) : '0;
    end
  end

  // ridge tests: c - n > thr done as c > n + thr in nine bits
  logic lane_hit, stop_hit;

  always_comb begin
    lane_hit = ({1'b0, win_mid} > {1'b0, win_far} + {1'b0, lane_thr_r}) &&
               ({1'b0, win_mid} > {1'b0, s1_px_r} + {1'b0, lane_thr_r}) &&
               (win_mid > bright_thr_r);
    stop_hit = ({1'b0, ls_mid} > {1'b0, ls_far} + {1'b0, stop_thr_r}) &&
               ({1'b0, ls_mid} > {1'b0, s1_px_r} + {1'b0, stop_thr_r});
  end

  // ---------------------------------------------------------- output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_v_r) begin
      out_lane_valid <= s1_lane_v_r;
      out_lane_row   <= s1_row_r;
      out_lane_col   <= s1_lane_col_r;
      out_lane_mark  <= s1_lane_v_r && lane_hit;
      out_stop_valid <= s1_stop_v_r;
      out_stop_row   <= s1_stop_row_r;
      out_stop_col   <= s1_col_r;
      out_stop_mark  <= s1_stop_v_r && stop_hit;
    end
  end

  assign out_valid = out_valid_r;

  // ------------------------------------------------------------ assertions
  // input backs up only when both stages are full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_lane_mark_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_lane_mark) |-> out_lane_valid)
    else $error("lane mark on a border column");

  a_stop_mark_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stop_mark) |-> out_stop_valid)
    else $error("stop mark on a border row");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !cfg_we) |=> (WW'(col_cnt_r) < w_r))
    else $error("column counter left the row");

  a_slot_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !cfg_we && (row_cnt_nxt == '0)) |=> (slot_r == '0))
    else $error("line-store slot out of step with row");

endmodule

@@ tb/tb_lane_and_stop_line_ridge_mask.sv @@
`timescale 1ns / 1ps
// Self-checking bench for lane_and_stop_line_ridge_mask: a directed table,
// extreme-size frames and random frames, scored against an in-bench predictor.
// Depends on lslrm_pkg and the block's RTL only.
module tb_lane_and_stop_line_ridge_mask;
  import lslrm_pkg::*;

  localparam int MAX_W    = MAX_WIDTH_DEF;
  localparam int MAX_H    = MAX_HEIGHT_DEF;
  localparam int MAX_LO   = MAX_LANE_OFFSET_DEF;
  localparam int MAX_SO   = MAX_STOP_OFFSET_DEF;
  localparam int WIN      = 2 * MAX_LO + 1;
  localparam int RING     = 2 * MAX_SO;
  localparam int DRAIN    = 4;        // idle wait before register writes
  localparam int LIMIT    = 800000;
  localparam int MAX_PRINT = 100;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic             lane_valid;
    logic [POS_W-1:0] lane_row;
    logic [POS_W-1:0] lane_col;
    logic             lane_mark;
    logic             stop_valid;
    logic [POS_W-1:0] stop_row;
    logic [POS_W-1:0] stop_col;
    logic             stop_mark;
  } ridge_res_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      gray;
    logic                  fs;
    bit                    typed;
    ridge_res_t            res;
  } dir_step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_gray = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_lane_valid;
  logic [POS_W-1:0]      out_lane_row;
  logic [POS_W-1:0]      out_lane_col;
  logic                  out_lane_mark;
  logic                  out_stop_valid;
  logic [POS_W-1:0]      out_stop_row;
  logic [POS_W-1:0]      out_stop_col;
  logic                  out_stop_mark;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lane_and_stop_line_ridge_mask i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_gray        (in_gray),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lane_valid (out_lane_valid),
    .out_lane_row   (out_lane_row),
    .out_lane_col   (out_lane_col),
    .out_lane_mark  (out_lane_mark),
    .out_stop_valid (out_stop_valid),
    .out_stop_row   (out_stop_row),
    .out_stop_col   (out_stop_col),
    .out_stop_mark  (out_stop_mark),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [11:0]      width_reg, height_reg;
  logic [5:0]       lane_off_reg, stop_off_reg;
  logic [7:0]       lane_thr_reg, stop_thr_reg, bright_reg;
  logic [PIX_W-1:0] hwin [0:WIN-1];
  logic [PIX_W-1:0] line_px [0:RING*MAX_W-1];
  bit               line_wr [0:RING*MAX_W-1];
  int unsigned      row_cnt, col_cnt;

  ridge_res_t  pending_marks[$];
  reg_write_t  cfg_q[$];
  dir_step_t   directed_tbl[$];
  int          errors = 0;
  int          stall_pct = 0;
  int          gap_pct = 0;
  int          stall_left = 0;
  int unsigned cycles = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void next_pos(input logic fs, output int unsigned row,
                                   output int unsigned col);
    int unsigned w, h;
    w = clampu(int'(width_reg), 1, MAX_W);
    h = clampu(int'(height_reg), 1, MAX_H);
    if (fs) begin
      row = 0;
      col = 0;
    end else begin
      row = row_cnt;
      col = col_cnt;
      if (col >= w) begin
        col = 0;
        row = row + 1;
      end
      if (row >= h) row = 0;
    end
  endfunction

  // A stop decision must never lean on a line-store entry never written.
  function automatic bit stop_reads_unwritten();
    int unsigned row, col, so;
    next_pos(1'b0, row, col);
    so = clampu(int'(stop_off_reg), 1, MAX_SO);
    if (row < 2 * so) return 1'b0;
    return !line_wr[((row + RING - so) % RING) * MAX_W + col] ||
           !line_wr[((row + RING - 2 * so) % RING) * MAX_W + col];
  endfunction

  task automatic reset_model();
    int i;
    width_reg    = 12'(RST_IMAGE_WIDTH);
    height_reg   = 12'(RST_IMAGE_HEIGHT);
    lane_off_reg = 6'(RST_LANE_OFFSET);
    lane_thr_reg = 8'(RST_LANE_THRESHOLD);
    stop_off_reg = 6'(RST_STOP_OFFSET);
    stop_thr_reg = 8'(RST_STOP_THRESHOLD);
    bright_reg   = 8'(RST_BRIGHT_THRESHOLD);
    for (i = 0; i < WIN; i++) hwin[i] = '0;
    row_cnt = 0;
    col_cnt = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_IMAGE_WIDTH:      width_reg    = d[11:0];
      REG_IMAGE_HEIGHT:     height_reg   = d[11:0];
      REG_LANE_OFFSET:      lane_off_reg = d[5:0];
      REG_LANE_THRESHOLD:   lane_thr_reg = d[7:0];
      REG_STOP_OFFSET:      stop_off_reg = d[5:0];
      REG_STOP_THRESHOLD:   stop_thr_reg = d[7:0];
      REG_BRIGHT_THRESHOLD: bright_reg   = d[7:0];
      default: ;
    endcase
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    reg_write_t e;
    e.idx  = idx;
    e.data = d;
    cfg_q  = {cfg_q, e};
  endtask

  // Judges the pixel lane_offset to the left and stop_offset above.
  task automatic mark_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                            output ridge_res_t r);
    int unsigned w, h, lo, so, row, col, now_ix;
    int          c, nb, p, lthr, sthr, bthr;
    int          i;
    w  = clampu(int'(width_reg), 1, MAX_W);
    h  = clampu(int'(height_reg), 1, MAX_H);
    lo = clampu(int'(lane_off_reg), 1, MAX_LO);
    so = clampu(int'(stop_off_reg), 1, MAX_SO);
    lthr = int'(lane_thr_reg);
    sthr = int'(stop_thr_reg);
    bthr = int'(bright_reg);
    p = int'(pix);
    r = '0;
    next_pos(fs, row, col);

    for (i = WIN - 1; i > 0; i--) hwin[i] = hwin[i-1];
    hwin[0] = pix;
    if (col >= 2 * lo) begin
      c = int'(hwin[lo]);
      nb = int'(hwin[2*lo]);
      r.lane_valid = 1'b1;
      r.lane_col   = POS_W'(col - lo);
      r.lane_mark  = (c - nb > lthr) && (c - p > lthr) && (c > bthr);
    end

    if (row >= 2 * so) begin
      c  = int'(line_px[((row + RING - so) % RING) * MAX_W + col]);
      nb = int'(line_px[((row + RING - 2 * so) % RING) * MAX_W + col]);
      r.stop_valid = 1'b1;
      r.stop_row   = POS_W'(row - so);
      r.stop_mark  = (c - nb > sthr) && (c - p > sthr);
    end
    now_ix = (row % RING) * MAX_W + col;
    line_px[now_ix] = pix;
    line_wr[now_ix] = 1'b1;

    r.lane_row = POS_W'(row);
    r.stop_col = POS_W'(col);

    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
      row_cnt = row;
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] g, input logic fs, input bit typed,
                            input ridge_res_t typed_res);
    ridge_res_t r;
    in_valid       <= 1'b1;
    in_gray        <= g;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mark_pixel(g, fs, r);
    if (typed) r = typed_res;
    pending_marks = {pending_marks, r};
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
  endtask

  // Register writes go in only with the pipeline drained.
  task automatic apply_cfg();
    in_valid <= 1'b0;
    while (pending_marks.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    while (cfg_q.size() != 0) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_q[0].idx;
      cfg_data  <= cfg_q[0].data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      write_reg(cfg_q[0].idx, cfg_q[0].data);
      void'(cfg_q.pop_front());
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frames(input int n_pix, input bit restart, input int noise_pct);
    logic [PIX_W-1:0] g;
    logic             fs;
    int               k, pick;
    for (k = 0; k < n_pix; k++) begin
      pick = $urandom_range(99);
      // dark road, bright paint, and anything in between
      if (pick < 40) g = PIX_W'($urandom_range(50, 0));
      else if (pick < 75) g = PIX_W'($urandom_range(255, 190));
      else g = PIX_W'($urandom_range(255, 0));
      fs = (k == 0 && restart) || ($urandom_range(99) < noise_pct) || stop_reads_unwritten();
      send_pixel(g, fs, 1'b0, '0);
    end
  endtask

  function automatic dir_step_t px(logic [PIX_W-1:0] g, logic fs);
    dir_step_t s;
    s = '{is_cfg: 1'b0, idx: '0, data: '0, gray: g, fs: fs, typed: 1'b0, res: '0};
    return s;
  endfunction

  // border pixel whose only nonzero fields are its position
  function automatic dir_step_t px_chk(logic [PIX_W-1:0] g, logic fs, int row, int col);
    dir_step_t s;
    s = px(g, fs);
    s.typed = 1'b1;
    s.res.lane_row = POS_W'(row);
    s.res.stop_col = POS_W'(col);
    return s;
  endfunction

  function automatic dir_step_t wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    dir_step_t s;
    s = '{is_cfg: 1'b1, idx: idx, data: d, gray: '0, fs: 1'b0, typed: 1'b0, res: '0};
    return s;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINT)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [POS_W-1:0] got,
                             input logic [POS_W-1:0] want);
    if (got !== want) report(what, int'(got), int'(want));
  endtask

  always @(posedge clk) begin : result_check
    ridge_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_marks.size() == 0) begin
        report("result with no request pending", 1, 0);
      end else begin
        want = pending_marks.pop_front();
        check_field("lane_valid", POS_W'(out_lane_valid), POS_W'(want.lane_valid));
        check_field("lane_row", out_lane_row, want.lane_row);
        check_field("lane_col", out_lane_col, want.lane_col);
        check_field("lane_mark", POS_W'(out_lane_mark), POS_W'(want.lane_mark));
        check_field("stop_valid", POS_W'(out_stop_valid), POS_W'(want.stop_valid));
        check_field("stop_row", out_stop_row, want.stop_row);
        check_field("stop_col", out_stop_col, want.stop_col);
        check_field("stop_mark", POS_W'(out_stop_mark), POS_W'(want.stop_mark));
      end
    end
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rst_n && $urandom_range(99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(13, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int               n, ph, k;
    int unsigned      v;
    logic [CFG_DATA_W-1:0] d;
    cfg_reg_t         ri;

    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    directed_tbl = '{
      // reset settings: top-left border pixels
      px_chk(8'd200, 1'b0, 0, 0),
      px_chk(8'd0, 1'b0, 0, 1),
      // width 0 acts as 1, so column 2 lies outside and the row advances
      wr(REG_IMAGE_WIDTH, 12'h000),
      wr(REG_IMAGE_HEIGHT, 12'hFFF),
      wr(REG_STOP_OFFSET, 12'hFC0),
      wr(REG_STOP_THRESHOLD, 12'h000),
      wr(REG_UNUSED, 12'hFFF),
      px_chk(8'd255, 1'b0, 1, 0),
      px(8'd10, 1'b0),
      px(8'd255, 1'b0),
      px(8'd0, 1'b0),
      // height shrinks below the current row: back to row 0
      wr(REG_IMAGE_HEIGHT, 12'd3),
      px_chk(8'd0, 1'b0, 0, 0),
      wr(REG_IMAGE_WIDTH, 12'd5),
      wr(REG_LANE_OFFSET, 12'hFC1),
      wr(REG_LANE_THRESHOLD, 12'h000),
      wr(REG_BRIGHT_THRESHOLD, 12'h000),
      px_chk(8'd0, 1'b1, 0, 0),
      px(8'd255, 1'b0),
      px(8'd0, 1'b0),
      px(8'd255, 1'b0),
      px(8'd255, 1'b0),
      px(8'd254, 1'b0),
      px(8'd0, 1'b0)
    };

    gap_pct   = 30;
    stall_pct = 30;
    for (n = 0; n < directed_tbl.size(); n++) begin
      if (directed_tbl[n].is_cfg) begin
        add_cfg(directed_tbl[n].idx, directed_tbl[n].data);
        if (n + 1 == directed_tbl.size() || !directed_tbl[n+1].is_cfg) apply_cfg();
      end else begin
        send_pixel(directed_tbl[n].gray, directed_tbl[n].fs, directed_tbl[n].typed,
                   directed_tbl[n].res);
      end
    end

    // widest row with the largest lane offset
    gap_pct   = 5;
    stall_pct = 10;
    add_cfg(REG_IMAGE_WIDTH, 12'h800);
    add_cfg(REG_IMAGE_HEIGHT, 12'h001);
    add_cfg(REG_LANE_OFFSET, 12'hFE0);
    add_cfg(REG_LANE_THRESHOLD, 12'd20);
    add_cfg(REG_BRIGHT_THRESHOLD, 12'd100);
    apply_cfg();
    run_frames(100, 1'b1, 0);

    // tallest frame, one pixel wide, largest stop offset
    add_cfg(REG_IMAGE_WIDTH, 12'h001);
    add_cfg(REG_IMAGE_HEIGHT, 12'h800);
    add_cfg(REG_STOP_OFFSET, 12'h020);
    add_cfg(REG_STOP_THRESHOLD, 12'd30);
    apply_cfg();
    run_frames(100, 1'b1, 0);

    for (ph = 0; ph < 10; ph++) begin
      if (ph >= 8) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(3))
          0: gap_pct = 0;
          1: gap_pct = 5;
          default: gap_pct = 30;
        endcase
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 25;
        endcase
      end
      for (k = 0; k < 7; k++) begin
        ri = cfg_reg_t'(k);
        if (ph == 0 || $urandom_range(99) < 70) begin
          d = CFG_DATA_W'($urandom);
          case (ri)
            REG_IMAGE_WIDTH: begin
              case ($urandom_range(9))
                0: d = 12'h000;
                1: d = 12'hFFF;
                2: d = CFG_DATA_W'($urandom_range(4095, 0));
                default: d = CFG_DATA_W'($urandom_range(12, 1));
              endcase
            end
            REG_IMAGE_HEIGHT: begin
              case ($urandom_range(9))
                0: d = 12'h000;
                1: d = 12'hFFF;
                2: d = 12'h800;
                default: d = CFG_DATA_W'($urandom_range(40, 1));
              endcase
            end
            REG_LANE_OFFSET, REG_STOP_OFFSET: begin
              case ($urandom_range(9))
                0: v = 0;
                1: v = 63;
                2: v = 32;
                default: v = $urandom_range(3, 1);
              endcase
              d[5:0] = 6'(v);
            end
            default: begin
              case ($urandom_range(5))
                0: v = 0;
                1: v = 255;
                2: v = $urandom_range(255, 0);
                default: v = $urandom_range(60, 0);
              endcase
              d[7:0] = 8'(v);
            end
          endcase
          add_cfg(ri, d);
        end
      end
      if ($urandom_range(99) < 20) add_cfg(REG_UNUSED, CFG_DATA_W'($urandom));
      apply_cfg();
      run_frames(40, $urandom_range(99) < 70, $urandom_range(3, 0));
    end

    in_valid <= 1'b0;
    while (pending_marks.size() != 0) @(posedge clk);
    repeat (4 * DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/lslrm_pkg.sv
hdl/lslrm_ram.sv
hdl/lane_and_stop_line_ridge_mask.sv
tb/tb_lane_and_stop_line_ridge_mask.sv
